// ----- rtl/ufc_pkg.sv -----
// Shared types and constants for the buffered serial port core.
`timescale 1ns / 1ps
`default_nettype none
package ufc_pkg;

	typedef enum logic [2:0] {
		ACT_WRITE    = 3'd0,
		ACT_READ     = 3'd1,
		ACT_RECV     = 3'd2,
		ACT_TX_DONE  = 3'd3,
		ACT_RESTART  = 3'd4,
		ACT_CLEAR_RX = 3'd5,
		ACT_FLUSH    = 3'd6,
		ACT_NONE     = 3'd7
	} action_t;

	typedef struct packed {
		action_t    action;
		logic [7:0] data_byte;
		logic       line_error;
		logic       cts_blocked;
	} cmd_t;

	typedef struct packed {
		logic       accepted;
		logic [7:0] read_data;
		logic       tx_valid;
		logic [7:0] tx_byte;
		logic       rts_hold;
		logic [5:0] tx_free;
		logic [5:0] rx_count;
	} rsp_t;

	localparam logic [1:0] CFG_IGNORE_CTS = 2'd0;
	localparam logic [1:0] CFG_RX_STOP    = 2'd1;
	localparam logic [1:0] CFG_RX_START   = 2'd2;

	typedef struct packed {
		logic [1:0] addr;
		logic [5:0] data;
	} cfg_wr_t;

	typedef struct packed {
		logic       ignore_cts;
		logic [5:0] rx_stop_level;
		logic [5:0] rx_start_level;
	} cfg_regs_t;

	localparam logic       RST_IGNORE_CTS = 1'b0;
	localparam logic [5:0] RST_RX_STOP    = 6'd8;
	localparam logic [5:0] RST_RX_START   = 6'd32;

endpackage
`default_nettype wire

// ----- rtl/ufc_chan_if.sv -----
// Valid/ready channel interface with a typed payload.
`timescale 1ns / 1ps
`default_nettype none
interface ufc_chan_if #(parameter type payload_t = logic);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ----- rtl/ufc_ram.sv -----
// Single-port-write, single-port-read synchronous RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module ufc_ram #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 8
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule
`default_nettype wire

// ----- rtl/ufc_cfg.sv -----
// Configuration register file for CTS handling and RTS thresholds.
`timescale 1ns / 1ps
`default_nettype none
module ufc_cfg import ufc_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	ufc_chan_if.sink   cfg,
	output cfg_regs_t  regs
);
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs.ignore_cts     <= RST_IGNORE_CTS;
			regs.rx_stop_level  <= RST_RX_STOP;
			regs.rx_start_level <= RST_RX_START;
		end else if (cfg.valid) begin
			case (cfg.payload.addr)
				CFG_IGNORE_CTS: regs.ignore_cts     <= cfg.payload.data[0];
				CFG_RX_STOP:    regs.rx_stop_level  <= cfg.payload.data;
				CFG_RX_START:   regs.rx_start_level <= cfg.payload.data;
				default: ;
			endcase
		end
	end
endmodule
`default_nettype wire

// ----- rtl/uart_ring_buffers_with_flow_control_top.sv -----
// Top level: transmit and receive rings in RAM with RTS/CTS flow control.
//
//  channel  dir  payload     beat happens when
//  cmd      in   cmd_t       cmd.valid && cmd.ready
//  rsp      out  rsp_t       rsp.valid && rsp.ready
//  cfg      in   cfg_wr_t    cfg.valid && cfg.ready (always ready)
//
// Each command has an accept step and an execute step: the accept step reads both ring RAMs at their tails,
// and the execute step uses the read data, writes back and loads the result register.
// A new command is not accepted until the current one has executed, since the RAM read data is registered.
// Execute stalls while the result register is full and not being taken.
// Reset clears pointers, counts, flags and configuration; the RAMs are not cleared.
`timescale 1ns / 1ps
`default_nettype none
module uart_ring_buffers_with_flow_control_top import ufc_pkg::*; #(
	parameter int TX_DEPTH = 64,
	parameter int RX_DEPTH = 64
) (
	input  wire logic clk,
	input  wire logic arst_n,
	ufc_chan_if.sink   cmd,
	ufc_chan_if.source rsp,
	ufc_chan_if.sink   cfg
);
	localparam int TPW = $clog2(TX_DEPTH);
	localparam int RPW = $clog2(RX_DEPTH);
	localparam int TCW = (TPW > 6) ? TPW : 6;
	localparam int RCW = (RPW > 6) ? RPW : 6;
	localparam logic [TPW-1:0] TX_CAP  = TPW'(TX_DEPTH - 1);
	localparam logic [RPW-1:0] RX_CAP  = RPW'(RX_DEPTH - 1);

	typedef enum logic {S_IDLE, S_EXEC} state_t;

	state_t         state_q;
	cmd_t           item_s1;
	rsp_t           out_q;
	logic           out_valid_q;
	logic [TPW-1:0] tx_head_q, tx_tail_q, tx_used_q;
	logic [RPW-1:0] rx_head_q, rx_tail_q, rx_used_q;
	logic           hold_q, tx_busy_q;

	logic [TPW-1:0] tx_head_n, tx_tail_n, tx_used_n;
	logic [RPW-1:0] rx_head_n, rx_tail_n, rx_used_n;
	logic           hold_n, tx_busy_n;
	logic           tx_we, rx_we, accept, fire, may_send;
	logic [7:0]     tx_rdata, rx_rdata;
	logic [TPW-1:0] tx_free_n;
	logic [TCW-1:0] tx_free_x;
	logic [RCW-1:0] rx_used_x;
	rsp_t           nxt;
	cfg_regs_t      regs;

	ufc_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	assign cmd.ready   = (state_q == S_IDLE);
	assign accept      = cmd.valid && cmd.ready;
	assign fire        = (state_q == S_EXEC) && (!out_valid_q || rsp.ready);
	assign rsp.valid   = out_valid_q;
	assign rsp.payload = out_q;

	ufc_ram #(.DEPTH(TX_DEPTH), .WIDTH(8)) u_tx_ram (
		.clk   (clk),
		.we    (tx_we),
		.waddr (tx_head_q),
		.wdata (item_s1.data_byte),
		.re    (accept),
		.raddr (tx_tail_q),
		.rdata (tx_rdata)
	);

	ufc_ram #(.DEPTH(RX_DEPTH), .WIDTH(8)) u_rx_ram (
		.clk   (clk),
		.we    (rx_we),
		.waddr (rx_head_q),
		.wdata (item_s1.data_byte),
		.re    (accept),
		.raddr (rx_tail_q),
		.rdata (rx_rdata)
	);

	function automatic logic [TPW-1:0] tx_next(input logic [TPW-1:0] p);
		return (p == TX_CAP) ? '0 : p + 1'b1;
	endfunction

	function automatic logic [RPW-1:0] rx_next(input logic [RPW-1:0] p);
		return (p == RX_CAP) ? '0 : p + 1'b1;
	endfunction

	assign may_send = regs.ignore_cts || !item_s1.cts_blocked;

	always_comb begin
		tx_head_n = tx_head_q;
		tx_tail_n = tx_tail_q;
		tx_used_n = tx_used_q;
		rx_head_n = rx_head_q;
		rx_tail_n = rx_tail_q;
		rx_used_n = rx_used_q;
		hold_n    = hold_q;
		tx_busy_n = tx_busy_q;
		tx_we     = 1'b0;
		rx_we     = 1'b0;
		nxt       = '0;
		case (item_s1.action)
			ACT_WRITE: begin
				if (tx_used_q != TX_CAP) begin
					tx_we        = fire;
					tx_head_n    = tx_next(tx_head_q);
					tx_used_n    = tx_used_q + 1'b1;
					nxt.accepted = 1'b1;
					if (may_send && !tx_busy_q) begin
						nxt.tx_valid = 1'b1;
						nxt.tx_byte  = (tx_used_q == '0) ? item_s1.data_byte : tx_rdata;
						tx_tail_n    = tx_next(tx_tail_q);
						tx_used_n    = tx_used_q;
						tx_busy_n    = 1'b1;
					end
				end
			end
			ACT_READ: begin
				if (rx_used_q != '0) begin
					nxt.accepted  = 1'b1;
					nxt.read_data = rx_rdata;
					rx_tail_n     = rx_next(rx_tail_q);
					rx_used_n     = rx_used_q - 1'b1;
					if (RCW'(RX_CAP - rx_used_n) > RCW'(regs.rx_start_level)) begin
						hold_n = 1'b0;
					end
				end else begin
					hold_n = 1'b0;
				end
			end
			ACT_RECV: begin
				if (!item_s1.line_error && rx_used_q != RX_CAP) begin
					rx_we     = fire;
					rx_head_n = rx_next(rx_head_q);
					rx_used_n = rx_used_q + 1'b1;
					if (RCW'(RX_CAP - rx_used_n) < RCW'(regs.rx_stop_level)) begin
						hold_n = 1'b1;
					end
				end
			end
			ACT_TX_DONE: begin
				tx_busy_n = 1'b0;
				if (may_send && tx_used_q != '0) begin
					nxt.tx_valid = 1'b1;
					nxt.tx_byte  = tx_rdata;
					tx_tail_n    = tx_next(tx_tail_q);
					tx_used_n    = tx_used_q - 1'b1;
					tx_busy_n    = 1'b1;
				end
			end
			ACT_RESTART: begin
				if (may_send && !tx_busy_q && tx_used_q != '0) begin
					nxt.tx_valid = 1'b1;
					nxt.tx_byte  = tx_rdata;
					tx_tail_n    = tx_next(tx_tail_q);
					tx_used_n    = tx_used_q - 1'b1;
					tx_busy_n    = 1'b1;
				end
			end
			ACT_CLEAR_RX: begin
				rx_head_n = '0;
				rx_tail_n = '0;
				rx_used_n = '0;
				hold_n    = 1'b0;
			end
			ACT_FLUSH: begin
				tx_head_n = '0;
				tx_tail_n = '0;
				tx_used_n = '0;
				rx_head_n = '0;
				rx_tail_n = '0;
				rx_used_n = '0;
			end
			default: ;
		endcase
		tx_free_n    = TX_CAP - tx_used_n;
		tx_free_x    = TCW'(tx_free_n);
		rx_used_x    = RCW'(rx_used_n);
		nxt.rts_hold = hold_n;
		nxt.tx_free  = tx_free_x[5:0];
		nxt.rx_count = rx_used_x[5:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			item_s1     <= '0;
			out_q       <= '0;
			out_valid_q <= 1'b0;
			tx_head_q   <= '0;
			tx_tail_q   <= '0;
			tx_used_q   <= '0;
			rx_head_q   <= '0;
			rx_tail_q   <= '0;
			rx_used_q   <= '0;
			hold_q      <= 1'b0;
			tx_busy_q   <= 1'b0;
		end else begin
			if (fire) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						item_s1 <= cmd.payload;
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (fire) begin
						out_q       <= nxt;
						tx_head_q   <= tx_head_n;
						tx_tail_q   <= tx_tail_n;
						tx_used_q   <= tx_used_n;
						rx_head_q   <= rx_head_n;
						rx_tail_q   <= rx_tail_n;
						rx_used_q   <= rx_used_n;
						hold_q      <= hold_n;
						tx_busy_q   <= tx_busy_n;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_exec_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EXEC && out_valid_q && !rsp.ready) |=> (state_q == S_EXEC))
		else $error("execute stage advanced while result register was blocked");

	a_tx_empty_ptrs: assert property (@(posedge clk) disable iff (!arst_n)
		(tx_used_q == '0) |-> (tx_head_q == tx_tail_q))
		else $error("transmit ring empty but pointers differ");

	a_rx_empty_ptrs: assert property (@(posedge clk) disable iff (!arst_n)
		(rx_used_q == '0) |-> (rx_head_q == rx_tail_q))
		else $error("receive ring empty but pointers differ");

	a_launch_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && nxt.tx_valid) |=> tx_busy_q)
		else $error("byte launched without marking transmitter busy");

endmodule
`default_nettype wire

// ----- tb/uart_ring_buffers_with_flow_control_top_test.sv -----
// Self-checking testbench for the buffered serial port core with RTS/CTS flow control.
`timescale 1ns / 1ps
module uart_ring_buffers_with_flow_control_top_test;
	import ufc_pkg::*;

	localparam int         CYCLE_LIMIT = 200000;
	localparam int         PHASE_ITEMS = 125;
	localparam logic [1:0] CFG_SPARE   = 2'd3;
	localparam logic [5:0] RING_CAP    = 6'd63;

	localparam int MODE_FILL_TX = 0;
	localparam int MODE_FILL_RX = 1;
	localparam int MODE_DRAIN   = 2;
	localparam int MODE_ANY     = 3;

	class serial_port_scoreboard;
		bit [7:0] tx_ring [64];
		bit [7:0] rx_ring [64];
		bit [5:0] tx_wr, tx_rd, tx_cnt, rx_wr, rx_rd, rx_cnt;
		bit       hold, busy;
		bit       ign_cts;
		bit [5:0] stop_lvl, start_lvl;
		rsp_t     due_status [$];
		int       n_items, n_errors, n_launch, n_refused, n_hold;

		function new();
			tx_wr = 0; tx_rd = 0; tx_cnt = 0;
			rx_wr = 0; rx_rd = 0; rx_cnt = 0;
			hold = 0; busy = 0;
			ign_cts = RST_IGNORE_CTS;
			stop_lvl = RST_RX_STOP;
			start_lvl = RST_RX_START;
		endfunction

		function int pending();
			return due_status.size();
		endfunction

		function void note_register(cfg_wr_t w);
			case (w.addr)
				CFG_IGNORE_CTS: ign_cts = w.data[0];
				CFG_RX_STOP: stop_lvl = w.data;
				CFG_RX_START: start_lvl = w.data;
				default: ;
			endcase
		endfunction

		function bit launch_head(output bit [7:0] b);
			b = 8'h00;
			if (tx_cnt == 0)
				return 1'b0;
			b = tx_ring[tx_rd];
			tx_rd++;
			tx_cnt--;
			busy = 1'b1;
			return 1'b1;
		endfunction

		function void note_command(cmd_t c);
			rsp_t     r;
			bit       may_send;
			bit [7:0] b;
			r = '0;
			may_send = ign_cts || !c.cts_blocked;
			n_items++;
			case (c.action)
				ACT_WRITE: begin
					if (tx_cnt < RING_CAP) begin
						tx_ring[tx_wr] = c.data_byte;
						tx_wr++;
						tx_cnt++;
						r.accepted = 1'b1;
						if (may_send && !busy && launch_head(b)) begin
							r.tx_valid = 1'b1;
							r.tx_byte = b;
						end
					end else begin
						n_refused++;
					end
				end
				ACT_READ: begin
					if (rx_cnt != 0) begin
						r.read_data = rx_ring[rx_rd];
						rx_rd++;
						rx_cnt--;
						r.accepted = 1'b1;
						if (RING_CAP - rx_cnt > start_lvl)
							hold = 1'b0;
					end else begin
						hold = 1'b0;
					end
				end
				ACT_RECV: begin
					if (!c.line_error && rx_cnt < RING_CAP) begin
						rx_ring[rx_wr] = c.data_byte;
						rx_wr++;
						rx_cnt++;
						if (RING_CAP - rx_cnt < stop_lvl) begin
							if (!hold)
								n_hold++;
							hold = 1'b1;
						end
					end
				end
				ACT_TX_DONE: begin
					busy = 1'b0;
					if (may_send && launch_head(b)) begin
						r.tx_valid = 1'b1;
						r.tx_byte = b;
					end
				end
				ACT_RESTART: begin
					if (may_send && !busy && launch_head(b)) begin
						r.tx_valid = 1'b1;
						r.tx_byte = b;
					end
				end
				ACT_CLEAR_RX: begin
					rx_wr = 0; rx_rd = 0; rx_cnt = 0;
					hold = 1'b0;
				end
				ACT_FLUSH: begin
					tx_wr = 0; tx_rd = 0; tx_cnt = 0;
					rx_wr = 0; rx_rd = 0; rx_cnt = 0;
				end
				default: ;
			endcase
			if (r.tx_valid)
				n_launch++;
			r.rts_hold = hold;
			r.tx_free = RING_CAP - tx_cnt;
			r.rx_count = rx_cnt;
			due_status.push_back(r);
		endfunction

		function void check_field(string f, logic [7:0] e, logic [7:0] a);
			if (a !== e) begin
				$display("%t: %s expected %0h, got %0h", $time, f, e, a);
				n_errors++;
			end
		endfunction

		function void check_response(rsp_t got);
			rsp_t e;
			if (due_status.size() == 0) begin
				$display("%t: response beat with none expected, got %h", $time, got);
				n_errors++;
				return;
			end
			e = due_status.pop_front();
			check_field("accepted", e.accepted, got.accepted);
			check_field("read_data", e.read_data, got.read_data);
			check_field("tx_valid", e.tx_valid, got.tx_valid);
			check_field("tx_byte", e.tx_byte, got.tx_byte);
			check_field("rts_hold", e.rts_hold, got.rts_hold);
			check_field("tx_free", e.tx_free, got.tx_free);
			check_field("rx_count", e.rx_count, got.rx_count);
		endfunction
	endclass

	logic clk;
	logic arst_n;
	bit   no_idle;
	int   cycles;
	int   n_settings;

	serial_port_scoreboard sb = new();

	ufc_chan_if #(.payload_t(cmd_t))    cmd_ch ();
	ufc_chan_if #(.payload_t(rsp_t))    rsp_ch ();
	ufc_chan_if #(.payload_t(cfg_wr_t)) cfg_ch ();

	uart_ring_buffers_with_flow_control_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd_ch),
		.rsp(rsp_ch),
		.cfg(cfg_ch)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_ch.valid && cfg_ch.ready)
				sb.note_register(cfg_ch.payload);
			if (cmd_ch.valid && cmd_ch.ready)
				sb.note_command(cmd_ch.payload);
			if (rsp_ch.valid && rsp_ch.ready)
				sb.check_response(rsp_ch.payload);
		end
	end

	always @(posedge clk) begin
		rsp_ch.ready <= no_idle || ($urandom_range(99) >= 28);
	end

	initial begin
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("Run stopped by the cycle limit with %0d responses outstanding.", sb.pending());
		$display("uart_ring_buffers_with_flow_control_top: mismatch");
		$finish;
	end

	function automatic cmd_t make_cmd(action_t a, logic [7:0] d, logic err, logic cts);
		cmd_t c;
		c.action = a;
		c.data_byte = d;
		c.line_error = err;
		c.cts_blocked = cts;
		return c;
	endfunction

	function automatic cmd_t random_cmd(int mode);
		cmd_t c;
		int   p;
		c.data_byte = 8'($urandom);
		c.line_error = ($urandom_range(7) == 0);
		c.cts_blocked = ($urandom_range(3) == 0);
		p = $urandom_range(99);
		case (mode)
			MODE_FILL_TX: c.action = (p < 70) ? ACT_WRITE : (p < 82) ? ACT_TX_DONE :
				(p < 90) ? ACT_RECV : (p < 96) ? ACT_READ : ACT_RESTART;
			MODE_FILL_RX: c.action = (p < 70) ? ACT_RECV : (p < 82) ? ACT_READ :
				(p < 90) ? ACT_WRITE : (p < 96) ? ACT_TX_DONE : ACT_RESTART;
			MODE_DRAIN: c.action = (p < 40) ? ACT_READ : (p < 75) ? ACT_TX_DONE :
				(p < 85) ? ACT_RESTART : (p < 93) ? ACT_WRITE : (p < 95) ? ACT_RECV :
				(p < 98) ? ACT_CLEAR_RX : ACT_FLUSH;
			default: c.action = action_t'($urandom_range(7));
		endcase
		return c;
	endfunction

	task automatic send_cmd(cmd_t c);
		while (!no_idle && $urandom_range(99) < 28) begin
			cmd_ch.valid <= 1'b0;
			@(posedge clk);
		end
		cmd_ch.valid <= 1'b1;
		cmd_ch.payload <= c;
		do @(posedge clk); while (!cmd_ch.ready);
	endtask

	task automatic set_flow_control(bit ign, logic [5:0] stop_lvl, logic [5:0] start_lvl,
			bit poke_spare);
		cfg_wr_t w [$];
		cmd_ch.valid <= 1'b0;
		do @(posedge clk); while (sb.pending() != 0);
		repeat (4) @(posedge clk);
		w.push_back('{CFG_IGNORE_CTS, {5'($urandom), ign}});
		w.push_back('{CFG_RX_STOP, stop_lvl});
		w.push_back('{CFG_RX_START, start_lvl});
		if (poke_spare)
			w.push_back('{CFG_SPARE, 6'($urandom)});
		foreach (w[i]) begin
			cfg_ch.valid <= 1'b1;
			cfg_ch.payload <= w[i];
			do @(posedge clk); while (!cfg_ch.ready);
		end
		cfg_ch.valid <= 1'b0;
		n_settings++;
	endtask

	task automatic run_random(int n);
		int mode;
		int left;
		int p;
		left = 0;
		mode = MODE_ANY;
		for (int i = 0; i < n; i++) begin
			if (left == 0) begin
				p = $urandom_range(99);
				mode = (p < 30) ? MODE_FILL_TX : (p < 60) ? MODE_FILL_RX :
					(p < 85) ? MODE_DRAIN : MODE_ANY;
				left = $urandom_range(140, 20);
			end
			send_cmd(random_cmd(mode));
			left--;
		end
	endtask

	initial begin
		arst_n = 1'b0;
		no_idle = 1'b0;
		n_settings = 0;
		cmd_ch.valid = 1'b0;
		cmd_ch.payload = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.payload = '0;
		rsp_ch.ready = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		set_flow_control(RST_IGNORE_CTS, RST_RX_STOP, RST_RX_START, 1'b0);
		send_cmd(make_cmd(ACT_READ, 8'h00, 1'b0, 1'b0));
		send_cmd(make_cmd(ACT_RESTART, 8'h00, 1'b0, 1'b0));
		send_cmd(make_cmd(ACT_TX_DONE, 8'h00, 1'b0, 1'b0));
		send_cmd(make_cmd(ACT_WRITE, 8'h00, 1'b0, 1'b0));
		send_cmd(make_cmd(ACT_WRITE, 8'hFF, 1'b0, 1'b0));
		send_cmd(make_cmd(ACT_WRITE, 8'hA5, 1'b1, 1'b1));
		send_cmd(make_cmd(ACT_TX_DONE, 8'h00, 1'b0, 1'b1));
		send_cmd(make_cmd(ACT_RESTART, 8'h00, 1'b0, 1'b1));
		send_cmd(make_cmd(ACT_RESTART, 8'h00, 1'b0, 1'b0));
		send_cmd(make_cmd(ACT_RESTART, 8'h00, 1'b0, 1'b0));
		send_cmd(make_cmd(ACT_RECV, 8'h00, 1'b0, 1'b0));
		send_cmd(make_cmd(ACT_RECV, 8'hFF, 1'b1, 1'b0));
		send_cmd(make_cmd(ACT_RECV, 8'h5A, 1'b0, 1'b1));
		send_cmd(make_cmd(ACT_READ, 8'hFF, 1'b1, 1'b1));
		send_cmd(make_cmd(ACT_READ, 8'h00, 1'b0, 1'b0));
		send_cmd(make_cmd(ACT_READ, 8'h00, 1'b0, 1'b0));
		send_cmd(make_cmd(ACT_NONE, 8'hFF, 1'b1, 1'b1));
		send_cmd(make_cmd(ACT_RECV, 8'h3C, 1'b0, 1'b0));
		send_cmd(make_cmd(ACT_CLEAR_RX, 8'h00, 1'b0, 1'b0));
		send_cmd(make_cmd(ACT_WRITE, 8'h11, 1'b0, 1'b0));
		send_cmd(make_cmd(ACT_FLUSH, 8'hFF, 1'b1, 1'b1));
		send_cmd(make_cmd(ACT_TX_DONE, 8'h00, 1'b0, 1'b0));
		send_cmd(make_cmd(ACT_WRITE, 8'h80, 1'b0, 1'b1));
		send_cmd(make_cmd(ACT_TX_DONE, 8'h00, 1'b0, 1'b0));

		run_random(PHASE_ITEMS);
		set_flow_control(1'b1, 6'd0, 6'd0, 1'b1);
		run_random(PHASE_ITEMS);
		set_flow_control(1'b0, 6'd63, 6'd63, 1'b0);
		no_idle = 1'b1;
		run_random(PHASE_ITEMS);
		no_idle = 1'b0;
		set_flow_control(1'b1, 6'd63, 6'd0, 1'b0);
		run_random(PHASE_ITEMS);
		set_flow_control(1'b0, 6'd0, 6'd63, 1'b1);
		run_random(PHASE_ITEMS);
		set_flow_control(1'($urandom), 6'($urandom), 6'($urandom), 1'b0);
		run_random(PHASE_ITEMS);

		cmd_ch.valid <= 1'b0;
		do @(posedge clk); while (sb.pending() != 0);
		repeat (8) @(posedge clk);
		$display("Checked %0d commands under %0d flow-control settings.", sb.n_items, n_settings);
		$display("Saw %0d bytes launched, %0d writes refused when full, %0d RTS hold-offs.",
			sb.n_launch, sb.n_refused, sb.n_hold);
		if (sb.n_errors == 0)
			$display("uart_ring_buffers_with_flow_control_top: match");
		else
			$display("uart_ring_buffers_with_flow_control_top: mismatch");
		$finish;
	end
endmodule

// ----- uart_ring_buffers_with_flow_control_top.f -----
rtl/ufc_pkg.sv
rtl/ufc_chan_if.sv
rtl/ufc_ram.sv
rtl/ufc_cfg.sv
rtl/uart_ring_buffers_with_flow_control_top.sv
tb/uart_ring_buffers_with_flow_control_top_test.sv
